// ----- rtl/core/b64e_pkg.sv -----
// Shared types, constants and the sextet-to-ASCII map for the base64 stream encoder.
// No dependencies; b64e_encode, b64e_emit and the top level import this package.
package b64e_pkg;

  localparam int LINE_CHARS_DEF = 72;
  localparam int COL_W          = 7;
  localparam int MAX_CHARS      = 5;
  localparam int CNT_W          = 3;

  localparam logic [7:0] CHAR_NL  = 8'h0a;
  localparam logic [7:0] CHAR_PAD = 8'h3d;

  // One encoded group: four characters, optionally a newline, and the end flag.
  typedef struct packed {
    logic [MAX_CHARS-1:0][7:0] chars;
    logic [CNT_W-1:0]          count;
    logic                      fin;
  } b64e_rec_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2b;
    end else begin
      c = 8'h2f;
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/b64e_in_if.sv -----
// Byte input channel of the base64 stream encoder: valid/ready plus payload.
// Depends on nothing.
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

// ----- rtl/core/b64e_out_if.sv -----
// Character output channel of the base64 stream encoder: valid/ready plus payload.
// Depends on nothing.
interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink (input valid, input out_char, input last_char, output ready);
endinterface

// ----- rtl/core/b64e_encode.sv -----
// Combinational group builder: folds one byte into the held bytes and, when a
// group closes or the message ends, builds the character record. Uses b64e_pkg.
module b64e_encode
  import b64e_pkg::*;
#(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic [7:0]       data_byte,
  input  logic             final_byte,
  input  logic [15:0]      pending,
  input  logic [1:0]       held,
  input  logic [COL_W-1:0] column,
  output logic             emits,
  output b64e_rec_t        rec,
  output logic [15:0]      pending_next,
  output logic [1:0]       held_next,
  output logic [COL_W-1:0] column_next
);

  logic [1:0]       held_eff;
  logic [23:0]      group;
  logic [COL_W-1:0] col_sum;
  logic             wrap;
  logic             full;

  always_comb begin
    held_eff = (held == 2'd3) ? 2'd2 : held;
    full     = (held_eff == 2'd2);
    emits    = full || final_byte;
    col_sum  = column + COL_W'(4);
    wrap     = (col_sum >= COL_W'(LINE_CHARS));

    unique case (held)
      2'd0:    group = {data_byte, 16'h0000};
      2'd1:    group = {pending[7:0], data_byte, 8'h00};
      default: group = {pending, data_byte};
    endcase

    rec.chars[0] = sextet_char(group[23:18]);
    rec.chars[1] = sextet_char(group[17:12]);
    rec.chars[2] = sextet_char(group[11:6]);
    rec.chars[3] = sextet_char(group[5:0]);
    rec.chars[4] = CHAR_NL;
    rec.fin      = final_byte;

    if (full) begin
      rec.count   = wrap ? CNT_W'(5) : CNT_W'(4);
      column_next = (final_byte || wrap) ? '0 : col_sum;
    end else begin
      // padded tail: pad does not count toward the line
      rec.chars[3] = CHAR_PAD;
      if (held_eff == 2'd0) begin
        rec.chars[2] = CHAR_PAD;
      end
      rec.count   = (column != '0) ? CNT_W'(5) : CNT_W'(4);
      column_next = final_byte ? '0 : column;
    end

    if (emits) begin
      pending_next = '0;
      held_next    = 2'd0;
    end else begin
      pending_next = {pending[7:0], data_byte};
      held_next    = held_eff + 2'd1;
    end
  end

endmodule

// ----- rtl/core/b64e_emit.sv -----
// Result register and character serializer: holds one group record and sends
// its characters one beat per cycle unless stalled. Uses b64e_pkg, b64e_out_if.
module b64e_emit
  import b64e_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  b64e_rec_t         rec_in,
  output logic              can_load,
  b64e_out_if.source        out_chars
);

  b64e_rec_t        rec;
  logic             busy;
  logic [CNT_W-1:0] idx;
  logic             at_end;
  logic             take;

  always_comb begin
    at_end              = (idx == rec.count - CNT_W'(1));
    take                = busy && out_chars.ready;
    can_load            = !busy || (take && at_end);
    out_chars.valid     = busy;
    out_chars.out_char  = rec.chars[idx];
    out_chars.last_char = rec.fin && at_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take) begin
      if (at_end) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec <= rec_in;
    end
  end

endmodule

// ----- rtl/core/base64_stream_encoder_top.sv -----
// Top level of the base64 stream encoder: group state and input handshake.
// Uses b64e_pkg, b64e_in_if, b64e_out_if, b64e_encode and b64e_emit.
//
// in_bytes carries one message byte per beat, final_byte set on the last one.
// out_chars carries one ASCII character per beat: base64 characters, '=' pad
// and newlines, last_char set on the final character of the message.
// Every third byte (or the final byte) closes a group that yields four or
// five characters; other bytes only update the held bits and give no output.
// The first character of a group is valid in the cycle after the byte that
// closes it is taken. The serializer then sends one character per cycle while
// the receiver is ready. Bytes that close no group are taken even while the
// serializer is busy; a byte that closes a group is taken in the cycle the
// previous group's last character leaves, or any time the serializer is empty.
// A stalled receiver holds the current character and, once the next group is
// built, holds back the input. Reset clears held bytes, the column count and
// the serializer; no character is pending after reset.
module base64_stream_encoder_top
  import b64e_pkg::*;
#(
  parameter int LINE_CHARS = LINE_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  b64e_in_if.sink     in_bytes,
  b64e_out_if.source  out_chars
);

  logic [15:0]      pending;
  logic [1:0]       held;
  logic [COL_W-1:0] column;

  logic [15:0]      pending_next;
  logic [1:0]       held_next;
  logic [COL_W-1:0] column_next;
  logic             emits;
  b64e_rec_t        rec;
  logic             can_load;
  logic             accept;

  b64e_encode #(
    .LINE_CHARS (LINE_CHARS)
  ) u_encode (
    .data_byte    (in_bytes.data_byte),
    .final_byte   (in_bytes.final_byte),
    .pending      (pending),
    .held         (held),
    .column       (column),
    .emits        (emits),
    .rec          (rec),
    .pending_next (pending_next),
    .held_next    (held_next),
    .column_next  (column_next)
  );

  b64e_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && emits),
    .rec_in    (rec),
    .can_load  (can_load),
    .out_chars (out_chars)
  );

  assign in_bytes.ready = !emits || can_load;
  assign accept         = in_bytes.valid && in_bytes.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      held    <= 2'd0;
      column  <= '0;
    end else if (accept) begin
      pending <= pending_next;
      held    <= held_next;
      column  <= column_next;
    end
  end

endmodule
